/* rtl/core/fph_pkg.sv */
`timescale 1ns / 1ps

package fph_pkg;

    localparam int NUM_DIMS  = 32;
    localparam int DIM_W     = 5;
    localparam int IDX_W     = 31;
    localparam int FRAC_W    = 32;
    localparam int PRIME_W   = 8;
    localparam int NUM_W     = IDX_W + PRIME_W;
    localparam int RECIP_W   = IDX_W + 1;
    localparam int PROD_W    = IDX_W + RECIP_W;
    localparam int SHIFT_W   = $clog2(NUM_W + 1);
    localparam int SIEVE_LIM = 8 * NUM_DIMS + 16;
    localparam int DIM_IDX_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int FAURE_LVL = 24;

    typedef logic [NUM_DIMS-1:0][PRIME_W-1:0] prime_tab_t;

    // sieve for the first NUM_DIMS primes
    function automatic prime_tab_t build_primes();
        prime_tab_t tab;
        bit         comp [SIEVE_LIM];
        int         cnt;
        tab = '0;
        cnt = 0;
        for (int i = 0; i < SIEVE_LIM; i++) begin
            comp[i] = 1'b0;
        end
        for (int i = 2; i < SIEVE_LIM; i++) begin
            if (!comp[i]) begin
                if (cnt < NUM_DIMS) begin
                    tab[cnt] = PRIME_W'(i);
                end
                cnt++;
                for (int j = i + i; j < SIEVE_LIM; j += i) begin
                    comp[j] = 1'b1;
                end
            end
        end
        return tab;
    endfunction

    localparam prime_tab_t PRIMES = build_primes();

    function automatic int perm_total(prime_tab_t p);
        int sum;
        sum = 0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            sum += int'(p[d]);
        end
        return sum;
    endfunction

    localparam int PERM_DEPTH = perm_total(PRIMES);
    localparam int ADDR_W     = $clog2(PERM_DEPTH);

    typedef logic [NUM_DIMS-1:0][ADDR_W-1:0]   offset_tab_t;
    typedef logic [NUM_DIMS-1:0][RECIP_W-1:0]  recip_tab_t;
    typedef logic [NUM_DIMS-1:0][SHIFT_W-1:0]  shift_tab_t;
    typedef logic [PERM_DEPTH-1:0][PRIME_W-1:0] perm_rom_t;

    function automatic offset_tab_t build_offsets(prime_tab_t p);
        offset_tab_t tab;
        int          off;
        off = 0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            tab[d] = ADDR_W'(off);
            off += int'(p[d]);
        end
        return tab;
    endfunction

    // digit divide runs as n * recip >> shift, shift = IDX_W + clog2(base)
    function automatic shift_tab_t build_shifts(prime_tab_t p);
        shift_tab_t tab;
        for (int d = 0; d < NUM_DIMS; d++) begin
            tab[d] = SHIFT_W'(IDX_W + $clog2(int'(p[d])));
        end
        return tab;
    endfunction

    // recip = floor(2^shift / base), bitwise long division
    function automatic recip_tab_t build_recips(prime_tab_t p);
        recip_tab_t  tab;
        logic [63:0] dvd;
        logic [63:0] quo;
        longint      rem;
        longint      b;
        for (int d = 0; d < NUM_DIMS; d++) begin
            b   = longint'(p[d]);
            dvd = 64'd1 << (IDX_W + $clog2(int'(p[d])));
            quo = '0;
            rem = 0;
            for (int i = 63; i >= 0; i--) begin
                rem = (rem << 1) | longint'(dvd[i]);
                if (rem >= b) begin
                    rem    = rem - b;
                    quo[i] = 1'b1;
                end
            end
            tab[d] = RECIP_W'(quo);
        end
        return tab;
    endfunction

    // faure permutation, recursion unrolled into a descent and an unwind
    function automatic int faure_map(int b, int k);
        int base;
        int kk;
        int depth;
        int v;
        int h;
        int m;
        bit odd_l [FAURE_LVL];
        int par   [FAURE_LVL];
        base  = b;
        kk    = k;
        depth = 0;
        v     = -1;
        for (int i = 0; i < FAURE_LVL; i++) begin
            odd_l[i] = 1'b0;
            par[i]   = 0;
        end
        for (int i = 0; i < FAURE_LVL; i++) begin
            if (v < 0) begin
                if (base <= 2) begin
                    v = kk & 1;
                end else if ((base & 1) == 0) begin
                    h            = base >> 1;
                    odd_l[depth] = 1'b0;
                    par[depth]   = (kk >= h) ? 1 : 0;
                    kk           = (kk >= h) ? kk - h : kk;
                    base         = h;
                    depth++;
                end else begin
                    m = (base - 1) >> 1;
                    if (kk == m) begin
                        v = m;
                    end else begin
                        odd_l[depth] = 1'b1;
                        par[depth]   = m;
                        kk           = (kk < m) ? kk : kk - 1;
                        base         = base - 1;
                        depth++;
                    end
                end
            end
        end
        for (int i = FAURE_LVL - 1; i >= 0; i--) begin
            if (i < depth) begin
                if (odd_l[i]) begin
                    v = v + ((v >= par[i]) ? 1 : 0);
                end else begin
                    v = 2 * v + par[i];
                end
            end
        end
        return v;
    endfunction

    function automatic perm_rom_t build_perm_rom(prime_tab_t p);
        perm_rom_t rom;
        int        off;
        int        b;
        rom = '0;
        off = 0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            b = int'(p[d]);
            for (int k = 0; k < b; k++) begin
                rom[off + k] = PRIME_W'(faure_map(b, k));
            end
            off += b;
        end
        return rom;
    endfunction

    localparam offset_tab_t OFFSETS  = build_offsets(PRIMES);
    localparam shift_tab_t  SHIFTS   = build_shifts(PRIMES);
    localparam recip_tab_t  RECIPS   = build_recips(PRIMES);
    localparam perm_rom_t   PERM_ROM = build_perm_rom(PRIMES);

endpackage

/* rtl/core/fph_perm_rom.sv */
`timescale 1ns / 1ps

module fph_perm_rom (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [fph_pkg::ADDR_W-1:0]  rd_addr,
    output logic [fph_pkg::PRIME_W-1:0] rd_data
);
    import fph_pkg::*;

    logic [PRIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= PERM_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/fph_digit_div.sv */
`timescale 1ns / 1ps

module fph_digit_div (
    input  logic                        aclk,
    input  logic                        ld,
    input  logic [fph_pkg::IDX_W-1:0]   n,
    input  logic [fph_pkg::PRIME_W-1:0] base,
    input  logic [fph_pkg::RECIP_W-1:0] recip,
    input  logic [fph_pkg::SHIFT_W-1:0] shift,
    output logic [fph_pkg::IDX_W-1:0]   quo,
    output logic [fph_pkg::PRIME_W-1:0] rem
);
    import fph_pkg::*;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_shr;
    logic [IDX_W-1:0]   q0;
    logic [NUM_W-1:0]   q0_b;
    logic [NUM_W-1:0]   r0_w;
    logic [PRIME_W:0]   r0;
    logic               fix;

    always_ff @(posedge aclk) begin
        if (ld) begin
            prod_reg <= PROD_W'(n) * PROD_W'(recip);
        end
    end

    // estimate is floor or one below it
    always_comb begin
        prod_shr = prod_reg >> shift;
        q0       = prod_shr[IDX_W-1:0];
        q0_b     = NUM_W'(q0) * NUM_W'(base);
        r0_w     = NUM_W'(n) - q0_b;
        r0       = r0_w[PRIME_W:0];
        fix      = (r0 >= {1'b0, base});
        quo      = q0 + IDX_W'(fix);
        rem      = fix ? PRIME_W'(r0 - {1'b0, base}) : r0[PRIME_W-1:0];
    end

endmodule

/* rtl/core/fph_frac_div.sv */
`timescale 1ns / 1ps

module fph_frac_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fph_pkg::NUM_W-1:0]  num,
    input  logic [fph_pkg::NUM_W-1:0]  den,
    output logic                       busy,
    output logic [fph_pkg::FRAC_W-1:0] quo
);
    import fph_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [NUM_W-1:0]  rem_reg,  rem_next;
    logic [NUM_W-1:0]  den_reg,  den_next;
    logic [FRAC_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic [NUM_W:0]    rem_sh;
    logic              take;

    // restoring division, one quotient bit per cycle; num < den always
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg, 1'b0};
        take      = (rem_sh >= {1'b0, den_reg});
        if (start) begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CNT_W'(FRAC_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = take ? NUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[NUM_W-1:0];
            quo_next  = {quo_reg[FRAC_W-2:0], take};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/core/faure_permuted_halton_sample.sv */
`timescale 1ns / 1ps
// each base-b digit of the index, lowest first, takes a reciprocal divide step and
// a permutation rom read; index zero skips the digit loop. a bit-serial final
// division then forms the fraction. one request in flight: the next is taken only
// after the last has moved to the output register, which holds off while an earlier
// result is unaccepted; a finished result waits in the output register while the next
// request is taken. synchronous active-low reset clears control.
module faure_permuted_halton_sample (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fph_pkg::DIM_W-1:0]  s_dimension,
    input  logic [fph_pkg::IDX_W-1:0]  s_sample_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [fph_pkg::FRAC_W-1:0] m_sample_fraction
);
    import fph_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_FIX   = 7'b0000100,
        S_LAST  = 7'b0001000,
        S_START = 7'b0010000,
        S_FRAC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t             state_reg,   state_next;
    logic [IDX_W-1:0]   n_reg,       n_next;
    logic [PRIME_W-1:0] base_reg,    base_next;
    logic [RECIP_W-1:0] recip_reg,   recip_next;
    logic [SHIFT_W-1:0] shift_reg,   shift_next;
    logic [ADDR_W-1:0]  off_reg,     off_next;
    logic [NUM_W-1:0]   num_reg,     num_next;
    logic [NUM_W-1:0]   den_reg,     den_next;
    logic               pend_reg,    pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [FRAC_W-1:0]  frac_reg,    frac_next;

    logic [DIM_IDX_W-1:0] dim_sat;
    logic [IDX_W-1:0]     div_quo;
    logic [PRIME_W-1:0]   div_rem;
    logic                 div_ld;
    logic                 rom_rd;
    logic [PRIME_W-1:0]   rom_data;
    logic                 fd_start;
    logic                 fd_busy;
    logic [FRAC_W-1:0]    fd_quo;
    logic [NUM_W-1:0]     num_acc;
    logic [NUM_W-1:0]     den_acc;

    fph_digit_div u_digit_div (
        .aclk  (aclk),
        .ld    (div_ld),
        .n     (n_reg),
        .base  (base_reg),
        .recip (recip_reg),
        .shift (shift_reg),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    fph_perm_rom u_perm_rom (
        .aclk    (aclk),
        .rd_en   (rom_rd),
        .rd_addr (off_reg + ADDR_W'(div_rem)),
        .rd_data (rom_data)
    );

    fph_frac_div u_frac_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fd_start),
        .num     (num_reg),
        .den     (den_reg),
        .busy    (fd_busy),
        .quo     (fd_quo)
    );

    always_comb begin
        dim_sat = (int'(s_dimension) >= NUM_DIMS) ? DIM_IDX_W'(NUM_DIMS - 1)
                                                  : DIM_IDX_W'(s_dimension);
        // digits enter lowest first, so the numerator grows by horner's rule
        num_acc = NUM_W'(num_reg * NUM_W'(base_reg)) + NUM_W'(rom_data);
        den_acc = NUM_W'(den_reg * NUM_W'(base_reg));
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        base_next    = base_reg;
        recip_next   = recip_reg;
        shift_next   = shift_reg;
        off_next     = off_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        frac_next    = frac_reg;
        div_ld       = 1'b0;
        rom_rd       = 1'b0;
        fd_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    n_next     = s_sample_index;
                    base_next  = PRIMES[dim_sat];
                    recip_next = RECIPS[dim_sat];
                    shift_next = SHIFTS[dim_sat];
                    off_next   = OFFSETS[dim_sat];
                    num_next   = '0;
                    den_next   = NUM_W'(1);
                    pend_next  = 1'b0;
                    state_next = (s_sample_index == '0) ? S_START : S_MUL;
                end
            end
            S_MUL: begin
                div_ld = 1'b1;
                if (pend_reg) begin
                    num_next = num_acc;
                    den_next = den_acc;
                end
                pend_next  = 1'b0;
                state_next = S_FIX;
            end
            S_FIX: begin
                rom_rd     = 1'b1;
                n_next     = div_quo;
                pend_next  = 1'b1;
                state_next = (div_quo == '0) ? S_LAST : S_MUL;
            end
            S_LAST: begin
                num_next   = num_acc;
                den_next   = den_acc;
                pend_next  = 1'b0;
                state_next = S_START;
            end
            S_START: begin
                fd_start   = 1'b1;
                state_next = S_FRAC;
            end
            S_FRAC: begin
                if (!fd_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    frac_next    = fd_quo;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        base_reg  <= base_next;
        recip_reg <= recip_next;
        shift_reg <= shift_next;
        off_reg   <= off_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        frac_reg  <= frac_next;
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_sample_fraction = frac_reg;

endmodule
